[design/rpbu_pkg.sv]
// ----------------------------------------------------------------------------
// rpbu_pkg
// Shared types and constants of the RGB pixel blend unit: the blend mode
// codes, the pixel payload structs and the divide-by-255 reciprocal.
// ----------------------------------------------------------------------------
package rpbu_pkg;

  // Blend mode codes as written to the configuration register.
  typedef enum logic [3:0] {
    BLEND_XOR        = 4'd0,
    BLEND_OVERLAY    = 4'd1,
    BLEND_SCREEN     = 4'd2,
    BLEND_MULTIPLY   = 4'd3,
    BLEND_ADD        = 4'd4,
    BLEND_SUBTRACT   = 4'd5,
    BLEND_DIFFERENCE = 4'd6,
    BLEND_DARKEN     = 4'd7,
    BLEND_LIGHTEN    = 4'd8,
    BLEND_DODGE      = 4'd9
  } mix_mode_e;

  // Input pixel pair.
  typedef struct packed {
    logic [7:0] bottom_red;
    logic [7:0] bottom_green;
    logic [7:0] bottom_blue;
    logic [7:0] top_red;
    logic [7:0] top_green;
    logic [7:0] top_blue;
    logic       frame_end_in;
  } pixel_in_t;

  // Blended output pixel.
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end_out;
  } pixel_out_t;

  // Channel full scale and the overlay split point.
  localparam logic [7:0] ChMax        = 8'd255;
  localparam logic [7:0] OverlaySplit = 8'd128;

  // floor(x / 255) == (x * Div255Mul) >> Div255Shift for every x below 2^17.
  localparam logic [17:0] Div255Mul   = 18'd131587;
  localparam int unsigned Div255Shift = 25;

  // Pipeline stages from an input transfer to the result at the output register.
  localparam int unsigned PipeDepth = 6;

endpackage

[design/rpbu_channel.sv]
// ----------------------------------------------------------------------------
// rpbu_channel
// Six-stage blend datapath for one color channel. Stage 1 forms the
// product or the simple result, stages 2-3 divide the product by 255,
// stages 2-5 run the color dodge division two quotient bits per stage,
// and stage 6 selects the result. All stages advance together on en_i.
// ----------------------------------------------------------------------------
module rpbu_channel (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  rpbu_pkg::mix_mode_e       mode_i,
  input  logic [7:0]                b_i,
  input  logic [7:0]                t_i,
  output logic [7:0]                res_o
);

  // One restoring division step: returns the quotient bit and the new remainder.
  function automatic logic [16:0] div_step(logic [15:0] rem, logic [7:0] den,
                                           logic [2:0] sh);
    logic [15:0] sd;
    sd = 16'(den) << sh;
    if (rem >= sd) begin
      return {1'b1, rem - sd};
    end
    return {1'b0, rem};
  endfunction

  // Stage 1 registers.
  rpbu_pkg::mix_mode_e s1_mode_q, s1_mode_d;
  logic [16:0] s1_prod_q, s1_prod_d;
  logic        s1_inv_q, s1_inv_d;
  logic [7:0]  s1_simple_q, s1_simple_d;
  logic [15:0] s1_num_q, s1_num_d;
  logic [7:0]  s1_den_q, s1_den_d;
  logic        s1_full_q, s1_full_d;

  // Stage 2 registers.
  rpbu_pkg::mix_mode_e s2_mode_q;
  logic [8:0]  s2_mq_q, s2_mq_d;
  logic        s2_inv_q;
  logic [7:0]  s2_simple_q;
  logic [15:0] s2_rem_q, s2_rem_d;
  logic [7:0]  s2_den_q;
  logic [7:0]  s2_quo_q, s2_quo_d;
  logic        s2_sat_q, s2_sat_d;
  logic        s2_full_q;

  // Stage 3 registers.
  rpbu_pkg::mix_mode_e s3_mode_q;
  logic [7:0]  s3_mul_q, s3_mul_d;
  logic [7:0]  s3_simple_q;
  logic [15:0] s3_rem_q, s3_rem_d;
  logic [7:0]  s3_den_q;
  logic [7:0]  s3_quo_q, s3_quo_d;
  logic        s3_sat_q;
  logic        s3_full_q;

  // Stage 4 registers.
  rpbu_pkg::mix_mode_e s4_mode_q;
  logic [7:0]  s4_mul_q;
  logic [7:0]  s4_simple_q;
  logic [15:0] s4_rem_q, s4_rem_d;
  logic [7:0]  s4_den_q;
  logic [7:0]  s4_quo_q, s4_quo_d;
  logic        s4_sat_q;
  logic        s4_full_q;

  // Stage 5 registers.
  rpbu_pkg::mix_mode_e s5_mode_q;
  logic [7:0]  s5_mul_q;
  logic [7:0]  s5_simple_q;
  logic [7:0]  s5_quo_q, s5_quo_d;
  logic        s5_sat_q;
  logic        s5_full_q;

  // Stage 6 (output) register.
  logic [7:0]  res_q, res_d;

  // Stage 1: multiplier operands, simple modes and dodge operands.
  logic [7:0]  mul_a, mul_c;
  logic [15:0] mul_p;
  logic        mul_dbl;
  logic [8:0]  sum;
  logic        lower_half;

  always_comb begin
    lower_half = (b_i < rpbu_pkg::OverlaySplit);
    sum        = {1'b0, b_i} + {1'b0, t_i};
    mul_a      = t_i;
    mul_c      = b_i;
    mul_dbl    = 1'b0;
    s1_inv_d   = 1'b0;
    s1_simple_d = b_i;
    case (mode_i)
      rpbu_pkg::BLEND_XOR:        s1_simple_d = b_i ^ t_i;
      rpbu_pkg::BLEND_OVERLAY: begin
        mul_dbl = 1'b1;
        if (!lower_half) begin
          mul_a    = rpbu_pkg::ChMax - t_i;
          mul_c    = rpbu_pkg::ChMax - b_i;
          s1_inv_d = 1'b1;
        end
      end
      rpbu_pkg::BLEND_SCREEN: begin
        mul_a    = rpbu_pkg::ChMax - t_i;
        mul_c    = rpbu_pkg::ChMax - b_i;
        s1_inv_d = 1'b1;
      end
      rpbu_pkg::BLEND_MULTIPLY:   s1_simple_d = b_i;
      rpbu_pkg::BLEND_ADD:        s1_simple_d = sum[8] ? rpbu_pkg::ChMax : sum[7:0];
      rpbu_pkg::BLEND_SUBTRACT:   s1_simple_d = (t_i > b_i) ? 8'd0 : b_i - t_i;
      rpbu_pkg::BLEND_DIFFERENCE: s1_simple_d = (t_i > b_i) ? t_i - b_i : b_i - t_i;
      rpbu_pkg::BLEND_DARKEN:     s1_simple_d = (t_i < b_i) ? t_i : b_i;
      rpbu_pkg::BLEND_LIGHTEN:    s1_simple_d = (t_i < b_i) ? b_i : t_i;
      default:                    s1_simple_d = b_i;
    endcase
    mul_p     = mul_a * mul_c;
    s1_prod_d = mul_dbl ? {mul_p, 1'b0} : {1'b0, mul_p};
    s1_mode_d = mode_i;
    s1_num_d  = {b_i, 8'd0} - {8'd0, b_i};
    s1_den_d  = rpbu_pkg::ChMax - t_i;
    s1_full_d = (t_i == rpbu_pkg::ChMax);
  end

  // Stage 2: reciprocal multiply, dodge saturation test and quotient bits 7..6.
  logic [34:0] recip_p;
  logic [16:0] st_a, st_b;

  always_comb begin
    recip_p  = s1_prod_q * rpbu_pkg::Div255Mul;
    s2_mq_d  = recip_p[rpbu_pkg::Div255Shift +: 9];
    s2_sat_d = ({1'b0, s1_num_q} >= {1'b0, s1_den_q, 8'd0});
    st_a     = div_step(s1_num_q, s1_den_q, 3'd7);
    st_b     = div_step(st_a[15:0], s1_den_q, 3'd6);
    s2_rem_d = st_b[15:0];
    s2_quo_d = {st_a[16], st_b[16], 6'd0};
  end

  // Stage 3: finish the mixing modes and quotient bits 5..4.
  logic [16:0] st_c, st_d;

  always_comb begin
    s3_mul_d = s2_inv_q ? rpbu_pkg::ChMax - s2_mq_q[7:0] : s2_mq_q[7:0];
    st_c     = div_step(s2_rem_q, s2_den_q, 3'd5);
    st_d     = div_step(st_c[15:0], s2_den_q, 3'd4);
    s3_rem_d = st_d[15:0];
    s3_quo_d = {s2_quo_q[7:6], st_c[16], st_d[16], 4'd0};
  end

  // Stage 4: quotient bits 3..2.
  logic [16:0] st_e, st_f;

  always_comb begin
    st_e     = div_step(s3_rem_q, s3_den_q, 3'd3);
    st_f     = div_step(st_e[15:0], s3_den_q, 3'd2);
    s4_rem_d = st_f[15:0];
    s4_quo_d = {s3_quo_q[7:4], st_e[16], st_f[16], 2'd0};
  end

  // Stage 5: quotient bits 1..0.
  logic [16:0] st_g, st_h;

  always_comb begin
    st_g     = div_step(s4_rem_q, s4_den_q, 3'd1);
    st_h     = div_step(st_g[15:0], s4_den_q, 3'd0);
    s5_quo_d = {s4_quo_q[7:2], st_g[16], st_h[16]};
  end

  // Stage 6: pick the result of the selected mode.
  always_comb begin
    case (s5_mode_q)
      rpbu_pkg::BLEND_OVERLAY,
      rpbu_pkg::BLEND_SCREEN,
      rpbu_pkg::BLEND_MULTIPLY: res_d = s5_mul_q;
      rpbu_pkg::BLEND_DODGE:    res_d = (s5_full_q || s5_sat_q) ? rpbu_pkg::ChMax : s5_quo_q;
      default:                  res_d = s5_simple_q;
    endcase
  end

  // Pipeline registers; payload only, so no reset.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_mode_q   <= s1_mode_d;
      s1_prod_q   <= s1_prod_d;
      s1_inv_q    <= s1_inv_d;
      s1_simple_q <= s1_simple_d;
      s1_num_q    <= s1_num_d;
      s1_den_q    <= s1_den_d;
      s1_full_q   <= s1_full_d;

      s2_mode_q   <= s1_mode_q;
      s2_mq_q     <= s2_mq_d;
      s2_inv_q    <= s1_inv_q;
      s2_simple_q <= s1_simple_q;
      s2_rem_q    <= s2_rem_d;
      s2_den_q    <= s1_den_q;
      s2_quo_q    <= s2_quo_d;
      s2_sat_q    <= s2_sat_d;
      s2_full_q   <= s1_full_q;

      s3_mode_q   <= s2_mode_q;
      s3_mul_q    <= s3_mul_d;
      s3_simple_q <= s2_simple_q;
      s3_rem_q    <= s3_rem_d;
      s3_den_q    <= s2_den_q;
      s3_quo_q    <= s3_quo_d;
      s3_sat_q    <= s2_sat_q;
      s3_full_q   <= s2_full_q;

      s4_mode_q   <= s3_mode_q;
      s4_mul_q    <= s3_mul_q;
      s4_simple_q <= s3_simple_q;
      s4_rem_q    <= s4_rem_d;
      s4_den_q    <= s3_den_q;
      s4_quo_q    <= s4_quo_d;
      s4_sat_q    <= s3_sat_q;
      s4_full_q   <= s3_full_q;

      s5_mode_q   <= s4_mode_q;
      s5_mul_q    <= s4_mul_q;
      s5_simple_q <= s4_simple_q;
      s5_quo_q    <= s5_quo_d;
      s5_sat_q    <= s4_sat_q;
      s5_full_q   <= s4_full_q;

      res_q       <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[design/rgb_pixel_blend_unit.sv]
// ----------------------------------------------------------------------------
// rgb_pixel_blend_unit
// Blends a top RGB pixel over a bottom RGB pixel with the configured mode.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i, in_data_i, in_stall_o) carries one pixel
// pair per transfer; the output channel (out_valid_o, out_data_o,
// out_stall_i) carries one blended pixel per transfer, in input order.
// The blend mode is written through cfg_valid_i / cfg_data_i; cfg_ready_o
// is always high. Write it only while no pixel is in flight.
// An input transfer reaches out_valid_o through the six pipeline stages. The
// block takes one pixel per cycle while no valid result is stalled by
// out_stall_i; the color dodge divider resolves two quotient bits per stage.
// Reset clears all valid bits and sets the mode to xor; the pipeline is
// empty and ready right after reset.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall_o rises in the same cycle; bubbles are not squeezed out, so a
// stalled pipeline holds at most six pixels.
// ----------------------------------------------------------------------------
module rgb_pixel_blend_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rpbu_pkg::pixel_in_t   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rpbu_pkg::pixel_out_t  out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [3:0]            cfg_data_i
);

  localparam int unsigned Depth = rpbu_pkg::PipeDepth;

  rpbu_pkg::mix_mode_e   mode_q;
  logic [Depth-1:0]      vld_q;
  logic [Depth-1:0]      fe_q;
  logic                  en;
  logic [7:0]            res_red, res_green, res_blue;

  // The pipeline moves unless a valid result is held by the receiver.
  assign en         = !vld_q[Depth-1] || !out_stall_i;
  assign in_stall_o = !en;

  // Mode register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= rpbu_pkg::BLEND_XOR;
    end else if (cfg_valid_i) begin
      mode_q <= rpbu_pkg::mix_mode_e'(cfg_data_i);
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  // Frame-end mark rides alongside.
  always_ff @(posedge clk_i) begin
    if (en) begin
      fe_q <= {fe_q[Depth-2:0], in_data_i.frame_end_in};
    end
  end

  // One datapath per color channel.
  rpbu_channel u_red (
    .clk_i  (clk_i),
    .en_i   (en),
    .mode_i (mode_q),
    .b_i    (in_data_i.bottom_red),
    .t_i    (in_data_i.top_red),
    .res_o  (res_red)
  );

  rpbu_channel u_green (
    .clk_i  (clk_i),
    .en_i   (en),
    .mode_i (mode_q),
    .b_i    (in_data_i.bottom_green),
    .t_i    (in_data_i.top_green),
    .res_o  (res_green)
  );

  rpbu_channel u_blue (
    .clk_i  (clk_i),
    .en_i   (en),
    .mode_i (mode_q),
    .b_i    (in_data_i.bottom_blue),
    .t_i    (in_data_i.top_blue),
    .res_o  (res_blue)
  );

  // Output register is the last pipeline stage.
  assign out_valid_o              = vld_q[Depth-1];
  assign out_data_o.out_red       = res_red;
  assign out_data_o.out_green     = res_green;
  assign out_data_o.out_blue      = res_blue;
  assign out_data_o.frame_end_out = fe_q[Depth-1];

endmodule

[design/rpbu_checker.sv]
// ----------------------------------------------------------------------------
// rpbu_checker
// Port-level assertions for the RGB pixel blend unit, bound to the top.
// ----------------------------------------------------------------------------
module rpbu_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_stall_o,
  input  logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  rpbu_pkg::pixel_out_t  out_data_o,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

  // The input is only stalled by a held result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // A held result always back-pressures the input.
  a_stall_prop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while the pipeline is held");

  // The mode register never refuses a write.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind rgb_pixel_blend_unit rpbu_checker u_checker (.*);

[bench/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_pixel_blend_unit. A directed pass walks every
// blend mode code, the unused ones included, with channel extremes, the
// overlay split and the color dodge corner cases. Random pixel pairs follow,
// one mode per phase. Each phase drains before the mode changes. A
// scoreboard class predicts each blended pixel and checks results in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned ItemsPerPhase = 62;
  localparam int unsigned RandomPhases  = 17;
  localparam int unsigned HoldCycles    = 40;
  localparam int unsigned WatchdogLimit = 5000;

  // Predicts blended pixels and checks them against the output stream.
  class blend_scoreboard;
    rpbu_pkg::pixel_out_t expected_pixels[$];
    logic [3:0]           mix_sel;
    int unsigned          mismatches;

    function new();
      mix_sel     = rpbu_pkg::BLEND_XOR;
      mismatches  = 0;
    endfunction

    // Blends one channel with the current mode; all math is done in 32 bits.
    function logic [7:0] blend_channel(logic [7:0] b8, logic [7:0] t8);
      int unsigned b;
      int unsigned t;
      int unsigned q;
      int unsigned full;
      int unsigned split;
      b     = b8;
      t     = t8;
      q     = b;
      full  = rpbu_pkg::ChMax;
      split = rpbu_pkg::OverlaySplit;
      case (mix_sel)
        rpbu_pkg::BLEND_XOR:        q = b ^ t;
        rpbu_pkg::BLEND_OVERLAY: begin
          if (b < split) q = (2 * t * b) / full;
          else q = full - (2 * (full - t) * (full - b)) / full;
        end
        rpbu_pkg::BLEND_SCREEN:     q = full - ((full - t) * (full - b)) / full;
        rpbu_pkg::BLEND_MULTIPLY:   q = (t * b) / full;
        rpbu_pkg::BLEND_ADD:        q = (t + b > full) ? full : t + b;
        rpbu_pkg::BLEND_SUBTRACT:   q = (t > b) ? 0 : b - t;
        rpbu_pkg::BLEND_DIFFERENCE: q = (t > b) ? t - b : b - t;
        rpbu_pkg::BLEND_DARKEN:     q = (t < b) ? t : b;
        rpbu_pkg::BLEND_LIGHTEN:    q = (t < b) ? b : t;
        rpbu_pkg::BLEND_DODGE: begin
          // A full top channel saturates; otherwise the quotient is clamped.
          if (t == full) begin
            q = full;
          end else begin
            q = (b * full) / (full - t);
            if (q > full) q = full;
          end
        end
        default:                    q = b;
      endcase
      return q[7:0];
    endfunction

    // Records the expected result of an accepted pixel pair.
    function void note_input(rpbu_pkg::pixel_in_t p);
      rpbu_pkg::pixel_out_t r;
      r.out_red       = blend_channel(p.bottom_red, p.top_red);
      r.out_green     = blend_channel(p.bottom_green, p.top_green);
      r.out_blue      = blend_channel(p.bottom_blue, p.top_blue);
      r.frame_end_out = p.frame_end_in;
      expected_pixels.push_back(r);
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    // Compares an accepted result with the oldest expectation, field by field.
    task check_result(rpbu_pkg::pixel_out_t r);
      rpbu_pkg::pixel_out_t e;
      if (expected_pixels.size() == 0) begin
        report($sformatf("result %h with nothing expected", r));
      end else begin
        e = expected_pixels.pop_front();
        if (r.out_red !== e.out_red)
          report($sformatf("out_red %0d, expected %0d", r.out_red, e.out_red));
        if (r.out_green !== e.out_green)
          report($sformatf("out_green %0d, expected %0d", r.out_green, e.out_green));
        if (r.out_blue !== e.out_blue)
          report($sformatf("out_blue %0d, expected %0d", r.out_blue, e.out_blue));
        if (r.frame_end_out !== e.frame_end_out)
          report($sformatf("frame_end_out %0b, expected %0b", r.frame_end_out,
                           e.frame_end_out));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  rpbu_pkg::pixel_in_t  in_data_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  rpbu_pkg::pixel_out_t out_data_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [3:0]           cfg_data_i;

  blend_scoreboard blend_sb;
  logic            idle_on;
  logic            hold_req;
  int unsigned     quiet_cycles;

  rgb_pixel_blend_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // Clock with a 4 ns period.
  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Watch every transfer at the rising edge, feed the scoreboard and
  // end the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) blend_sb.mix_sel = cfg_data_i;
      if (in_valid_i && !in_stall_o) blend_sb.note_input(in_data_i);
      if (out_valid_o && !out_stall_i) blend_sb.check_result(out_data_o);
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: short random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req    = 1'b0;
        out_stall_i = 1'b0;
      end else if (idle_on && rst_ni && $urandom_range(0, 4) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  function automatic rpbu_pkg::pixel_in_t make_pixel(logic [7:0] br, logic [7:0] bg,
                                                     logic [7:0] bb, logic [7:0] tr,
                                                     logic [7:0] tg, logic [7:0] tb,
                                                     logic fe);
    rpbu_pkg::pixel_in_t p;
    p.bottom_red   = br;
    p.bottom_green = bg;
    p.bottom_blue  = bb;
    p.top_red      = tr;
    p.top_green    = tg;
    p.top_blue     = tb;
    p.frame_end_in = fe;
    return p;
  endfunction

  // Channel value biased toward the corners of the blend formulas.
  function automatic logic [7:0] rand_channel();
    logic [7:0] corner_vals[6];
    corner_vals = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    if ($urandom_range(0, 3) == 0) return corner_vals[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic rpbu_pkg::pixel_in_t rand_pixel();
    return make_pixel(rand_channel(), rand_channel(), rand_channel(),
                      rand_channel(), rand_channel(), rand_channel(),
                      $urandom_range(0, 7) == 0);
  endfunction

  // Offers one pixel pair, maybe after a short gap, and waits for its transfer.
  task automatic send_pixel(input rpbu_pkg::pixel_in_t p);
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = p;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drops valid and waits until every expected pixel has come out.
  task automatic drain_pixels();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (blend_sb.pending() != 0) @(posedge clk_i);
  endtask

  // Writes the blend mode; the pipeline is empty when this is called.
  task automatic write_mode(input logic [3:0] mode);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    logic [3:0] mode;
    blend_sb     = new();
    quiet_cycles = 0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: every mode code with channel extremes and a dodge overflow.
    for (int m = 0; m < 16; m++) begin
      write_mode(4'(m));
      send_pixel(make_pixel(8'd0, 8'd255, 8'd200, 8'd255, 8'd0, 8'd100, m[0]));
      drain_pixels();
    end
    // Overlay around its split point.
    write_mode(rpbu_pkg::BLEND_OVERLAY);
    send_pixel(make_pixel(8'd127, 8'd128, 8'd255, 8'd200, 8'd200, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd128, 8'd127, 8'd0, 8'd0, 8'd255, 8'd1, 1'b1));
    drain_pixels();
    // Dodge with a full top channel, a zero bottom and a near-full top.
    write_mode(rpbu_pkg::BLEND_DODGE);
    send_pixel(make_pixel(8'd0, 8'd255, 8'd1, 8'd255, 8'd255, 8'd254, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd127, 8'd128, 8'd0, 8'd128, 8'd127, 1'b1));
    drain_pixels();

    // Random phases, one mode each; the last one runs without idling.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      mode = (ph < 16) ? 4'(ph) : 4'($urandom_range(0, 15));
      if (ph == RandomPhases - 1) idle_on = 1'b0;
      write_mode(mode);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // Long receiver hold-off while the sender keeps offering pixels.
        if (ph == 5 && n == 20) hold_req = 1'b1;
        send_pixel(rand_pixel());
      end
      drain_pixels();
    end

    repeat (rpbu_pkg::PipeDepth + 4) @(posedge clk_i);
    if (blend_sb.pending() != 0)
      blend_sb.report($sformatf("%0d results never arrived", blend_sb.pending()));
    if (blend_sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
